@@ design/npm_pkg.sv @@
// ----------------------------------------------------------------------------
// npm_pkg
// Shared field widths and operation/result codes for the neighbour point
// matcher.
// ----------------------------------------------------------------------------
package npm_pkg;

  localparam int FIELD_W = 12;
  localparam int OP_W    = 2;
  localparam int KIND_W  = 2;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_PROBE = 2'd1;
  localparam op_t OP_FLUSH = 2'd2;

  localparam kind_t KIND_MATCH     = 2'd0;
  localparam kind_t KIND_UNMATCHED = 2'd1;
  localparam kind_t KIND_DONE      = 2'd2;

endpackage

@@ design/npm_ram.sv @@
// ----------------------------------------------------------------------------
// npm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module npm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/neighbour_point_match.sv @@
// ----------------------------------------------------------------------------
// neighbour_point_match
// Matches detected points against a stored list of reference points within
// a 3x3 pixel neighbourhood, and reports unmatched references on flush.
// ----------------------------------------------------------------------------
// Sequence: a load transaction yields no result. A probe or a flush reads
// each stored entry in turn through the single RAM port and compares it
// once its read data returns, then drains the pending slot to the output
// register; a flush then also sends the done result. A hit that meets a
// stalled output holds the scan, and the final result waits for the output.
// No new transaction is taken until a probe or flush has finished.
// Throughput: one load per cycle while no probe or flush is in progress.
// Reset: synchronous, active low; clears the count, the matched flags, the
// overflow flag and all handshake state. The reference RAM is not cleared.
// ----------------------------------------------------------------------------
module neighbour_point_match import npm_pkg::*; #(
  parameter int REF_DEPTH  = 32,
  parameter int COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [FIELD_W-1:0] in_x,
  input  logic [FIELD_W-1:0] in_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_kind,
  output logic [FIELD_W-1:0] out_ref_x,
  output logic [FIELD_W-1:0] out_ref_y,
  output logic [FIELD_W-1:0] out_det_x,
  output logic [FIELD_W-1:0] out_det_y,
  output logic               out_last,
  output logic               out_overflow
);

  localparam int IDX_W  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CNT_W  = $clog2(REF_DEPTH + 1);
  localparam int PAIR_W = 2 * COORD_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  typedef logic [COORD_BITS-1:0] coord_t;

  // Coordinates differ by at most one, compared without wrap.
  function automatic logic near_axis(input coord_t a, input coord_t b);
    logic [COORD_BITS:0] ae;
    logic [COORD_BITS:0] be;
    ae = {1'b0, a};
    be = {1'b0, b};
    return (ae == be) || ((ae + 1'b1) == be) || ((be + 1'b1) == ae);
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input coord_t v);
    logic [FIELD_W+COORD_BITS-1:0] t;
    t = {{FIELD_W{1'b0}}, v};
    return t[FIELD_W-1:0];
  endfunction

  function automatic coord_t from_field(input logic [FIELD_W-1:0] v);
    logic [FIELD_W+COORD_BITS-1:0] t;
    t = {{COORD_BITS{1'b0}}, v};
    return t[COORD_BITS-1:0];
  endfunction

  // Control state
  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [REF_DEPTH-1:0] flags_r, flags_nxt;
  logic [CNT_W-1:0]     iss_r, iss_nxt;
  logic                 eval_v_r, eval_v_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic                 out_v_r, out_v_nxt;

  // Payload state
  logic                 is_flush_r, is_flush_nxt;
  coord_t               px_r, px_nxt;
  coord_t               py_r, py_nxt;
  logic [IDX_W-1:0]     eval_idx_r, eval_idx_nxt;
  kind_t                pend_kind_r, pend_kind_nxt;
  coord_t               pend_rx_r, pend_rx_nxt;
  coord_t               pend_ry_r, pend_ry_nxt;
  coord_t               pend_dx_r, pend_dx_nxt;
  coord_t               pend_dy_r, pend_dy_nxt;
  logic                 pend_ovf_r, pend_ovf_nxt;
  kind_t                out_kind_r;
  logic [FIELD_W-1:0]   out_rx_r, out_ry_r, out_dx_r, out_dy_r;
  logic                 out_last_r, out_ovf_r;

  // RAM port
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [PAIR_W-1:0]    wr_data;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [PAIR_W-1:0]    rd_data;

  coord_t               ref_c, ref_r, px_in, py_in;
  logic                 out_free, hit, stall, push, push_last;

  npm_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (REF_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ref_c    = rd_data[PAIR_W-1:COORD_BITS];
  assign ref_r    = rd_data[COORD_BITS-1:0];
  assign px_in    = from_field(in_x);
  assign py_in    = from_field(in_y);
  assign out_free = !out_v_r || out_ready;

  // The entry read last cycle is compared now: on a probe it hits when it is
  // a neighbour, on a flush when it was never matched.
  assign hit = eval_v_r && (is_flush_r ? !flags_r[eval_idx_r]
                                       : (near_axis(ref_c, px_r) && near_axis(ref_r, py_r)));
  // A hit needs the pending slot; when that slot has to drain into a busy
  // output register, hold the scan and re-read the same entry.
  assign stall = hit && pend_v_r && !out_free;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    flags_nxt     = flags_r;
    iss_nxt       = iss_r;
    eval_v_nxt    = eval_v_r;
    eval_idx_nxt  = eval_idx_r;
    pend_v_nxt    = pend_v_r;
    is_flush_nxt  = is_flush_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pend_kind_nxt = pend_kind_r;
    pend_rx_nxt   = pend_rx_r;
    pend_ry_nxt   = pend_ry_r;
    pend_dx_nxt   = pend_dx_r;
    pend_dy_nxt   = pend_dy_r;
    pend_ovf_nxt  = pend_ovf_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[IDX_W-1:0];
    wr_data       = {px_in, py_in};
    rd_en         = 1'b0;
    rd_addr       = eval_idx_r;
    push          = 1'b0;
    push_last     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_LOAD: begin
              // Append while there is room; otherwise drop and flag overflow.
              if (cnt_r < CNT_W'(REF_DEPTH)) begin
                wr_en                         = 1'b1;
                flags_nxt[cnt_r[IDX_W-1:0]]   = 1'b0;
                cnt_nxt                       = CNT_W'(cnt_r + 1'b1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_PROBE, OP_FLUSH: begin
              is_flush_nxt = (in_opcode == OP_FLUSH);
              px_nxt       = px_in;
              py_nxt       = py_in;
              iss_nxt      = '0;
              eval_v_nxt   = 1'b0;
              state_nxt    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (stall) begin
          rd_en   = 1'b1;
          rd_addr = eval_idx_r;
        end else begin
          if (hit) begin
            // Move the older hit out; it cannot be the last one.
            if (pend_v_r) begin
              push      = 1'b1;
              push_last = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_kind_nxt = is_flush_r ? KIND_UNMATCHED : KIND_MATCH;
            pend_rx_nxt   = ref_c;
            pend_ry_nxt   = ref_r;
            pend_dx_nxt   = is_flush_r ? '0 : px_r;
            pend_dy_nxt   = is_flush_r ? '0 : py_r;
            pend_ovf_nxt  = 1'b0;
            if (!is_flush_r) begin
              flags_nxt[eval_idx_r] = 1'b1;
            end
          end
          if (iss_r != cnt_r) begin
            rd_en        = 1'b1;
            rd_addr      = iss_r[IDX_W-1:0];
            eval_v_nxt   = 1'b1;
            eval_idx_nxt = iss_r[IDX_W-1:0];
            iss_nxt      = CNT_W'(iss_r + 1'b1);
          end else begin
            eval_v_nxt = 1'b0;
            state_nxt  = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (pend_v_r) begin
          if (out_free) begin
            push      = 1'b1;
            push_last = !is_flush_r || (pend_kind_r == KIND_DONE);
            if (is_flush_r && (pend_kind_r != KIND_DONE)) begin
              pend_kind_nxt = KIND_DONE;
              pend_rx_nxt   = '0;
              pend_ry_nxt   = '0;
              pend_dx_nxt   = '0;
              pend_dy_nxt   = '0;
              pend_ovf_nxt  = ovf_r;
            end else begin
              pend_v_nxt = 1'b0;
              state_nxt  = ST_IDLE;
              if (is_flush_r) begin
                cnt_nxt   = '0;
                flags_nxt = '0;
                ovf_nxt   = 1'b0;
              end
            end
          end
        end else if (is_flush_r) begin
          // Empty or fully matched store: only the done result follows.
          pend_v_nxt    = 1'b1;
          pend_kind_nxt = KIND_DONE;
          pend_rx_nxt   = '0;
          pend_ry_nxt   = '0;
          pend_dx_nxt   = '0;
          pend_dy_nxt   = '0;
          pend_ovf_nxt  = ovf_r;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Output register: load on push, drop once taken.
    if (push) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      flags_r  <= '0;
      iss_r    <= '0;
      eval_v_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      flags_r  <= flags_nxt;
      iss_r    <= iss_nxt;
      eval_v_r <= eval_v_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_flush_r  <= is_flush_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    eval_idx_r  <= eval_idx_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_rx_r   <= pend_rx_nxt;
    pend_ry_r   <= pend_ry_nxt;
    pend_dx_r   <= pend_dx_nxt;
    pend_dy_r   <= pend_dy_nxt;
    pend_ovf_r  <= pend_ovf_nxt;
    if (push) begin
      out_kind_r <= pend_kind_r;
      out_rx_r   <= to_field(pend_rx_r);
      out_ry_r   <= to_field(pend_ry_r);
      out_dx_r   <= to_field(pend_dx_r);
      out_dy_r   <= to_field(pend_dy_r);
      out_last_r <= push_last;
      out_ovf_r  <= pend_ovf_r;
    end
  end

  assign out_valid    = out_v_r;
  assign out_kind     = out_kind_r;
  assign out_ref_x    = out_rx_r;
  assign out_ref_y    = out_ry_r;
  assign out_det_x    = out_dx_r;
  assign out_det_y    = out_dy_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  // Input is taken only with no scan in flight and nothing pending.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!eval_v_r && !pend_v_r))
    else $error("input taken while scan state is live");

  // The reference count never passes the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(REF_DEPTH))
    else $error("reference count exceeds depth");

  // A new result never overwrites one still waiting at the output.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!out_v_r || out_ready))
    else $error("output register overwritten");

  // Sending the done result empties the store.
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && is_flush_r && pend_v_r && pend_kind_r == KIND_DONE && out_free)
    |=> (cnt_r == '0 && !ovf_r && flags_r == '0))
    else $error("flush did not clear the store");

  // A done result always closes its transaction.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_kind_r == KIND_DONE) |-> out_last_r)
    else $error("done result without last");

endmodule
